/* hdl/ohe_pkg.sv */
// Shared types and codes of the one-hot category encoder.
package ohe_pkg;

	localparam int OP_W     = 2;
	localparam int STATUS_W = 3;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR  = 2'd0,
		OP_LEARN  = 2'd1,
		OP_ENCODE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 3'd0,
		ST_PRESENT     = 3'd1,
		ST_NOT_FOUND   = 3'd2,
		ST_FULL        = 3'd3,
		ST_BAD_FEATURE = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_PUT,
		S_OFFSET
	} state_t;

endpackage

/* hdl/ohe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ohe_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hdl/ohe_unit.sv */
// Shared signed comparator and accumulator adder of the encoder.
module ohe_unit #(
	parameter int VW = 16,
	parameter int SW = 7
) (
	input  logic signed [VW-1:0] a,
	input  logic signed [VW-1:0] b,
	input  logic [SW-1:0]        x,
	input  logic [SW-1:0]        y,
	output logic                 lt,
	output logic                 eq,
	output logic [SW-1:0]        sum
);

	assign lt  = a < b;
	assign eq  = a == b;
	assign sum = x + y;

endmodule

/* hdl/one_hot_category_encoder_unit.sv */
// Top level of the one-hot category encoder: sequencer, counts and table RAM.
//
// Channel   Direction  Handshake                Payload
// command   in         start & !busy            operation, feature_index, category_value
// result    out        done (one-cycle strobe)  status, category_rank, onehot_column,
//                                               feature_categories
// config    in         cfg_wr_en                cfg_wr_data (feature_count)
//
// Clear, unused codes and bad features answer in the cycle after acceptance.  Else the
// table is scanned over the single RAM read port, a read and a compare state per entry.
// A learn that inserts then shifts larger entries up and writes the value; an encode
// that hits sums the lower features' counts.  Present, full and not-found stop there.
// Reset clears the counts and sets feature_count to 1; the table needs no clearing.
// The receiver cannot stall; busy is high while a beat is being worked on.
module one_hot_category_encoder_unit #(
	parameter int MAX_FEATURES   = 8,
	parameter int MAX_CATEGORIES = 16,
	parameter int VALUE_WIDTH    = 16,
	localparam int FIDX_W = MAX_FEATURES > 1 ? $clog2(MAX_FEATURES) : 1,
	localparam int FC_W   = $clog2(MAX_FEATURES + 1),
	localparam int CNT_W  = $clog2(MAX_CATEGORIES + 1),
	localparam int RANK_W = $clog2(MAX_CATEGORIES),
	localparam int COL_W  = MAX_FEATURES * MAX_CATEGORIES > 1 ?
	                        $clog2(MAX_FEATURES * MAX_CATEGORIES) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [FC_W-1:0]               cfg_wr_data,
	input  logic                          start,
	output logic                          busy,
	input  logic [ohe_pkg::OP_W-1:0]      operation,
	input  logic [FIDX_W-1:0]             feature_index,
	input  logic signed [VALUE_WIDTH-1:0] category_value,
	output logic                          done,
	output logic [ohe_pkg::STATUS_W-1:0]  status,
	output logic [RANK_W-1:0]             category_rank,
	output logic [COL_W-1:0]              onehot_column,
	output logic [CNT_W-1:0]              feature_categories
);

	import ohe_pkg::*;

	localparam int DEPTH  = MAX_FEATURES * MAX_CATEGORIES;
	localparam int ADDR_W = $clog2(DEPTH > 1 ? DEPTH : 2);

	state_t state_q, state_d;

	logic [FC_W-1:0]               fc_q;
	logic [CNT_W-1:0]              counts_q [MAX_FEATURES];
	op_t                           op_q;
	logic [FIDX_W-1:0]             f_q;
	logic [FIDX_W-1:0]             fk_q;
	logic signed [VALUE_WIDTH-1:0] v_q;
	logic [CNT_W-1:0]              k_q;
	logic [CNT_W-1:0]              n_q;
	logic [CNT_W-1:0]              rank_q;
	logic                          hit_q;
	logic [COL_W-1:0]              acc_q;

	logic                          done_q;
	status_t                       status_q;
	logic [RANK_W-1:0]             res_rank_q;
	logic [COL_W-1:0]              res_col_q;
	logic [CNT_W-1:0]              res_cats_q;

	logic                          accept;
	logic                          bad;
	logic [FIDX_W-1:0]             cnt_sel;
	logic [CNT_W-1:0]              cnt_rd;
	logic [ADDR_W-1:0]             base;
	logic [ADDR_W-1:0]             raddr;
	logic [ADDR_W-1:0]             waddr;
	logic                          we;
	logic [VALUE_WIDTH-1:0]        wdata;
	logic [VALUE_WIDTH-1:0]        rdata;
	logic                          lt, eq;
	logic [COL_W-1:0]              addend;
	logic [COL_W-1:0]              sum;
	logic [CNT_W-1:0]              k_dec;

	assign accept = start && !busy;
	assign bad    = (32'(feature_index) >= 32'(fc_q)) || (32'(feature_index) >= MAX_FEATURES);

	assign cnt_sel = (state_q == S_IDLE) ? feature_index : fk_q;
	assign cnt_rd  = counts_q[cnt_sel];

	assign base  = ADDR_W'(32'(f_q) * MAX_CATEGORIES);
	assign k_dec = k_q - CNT_W'(1);
	assign raddr = base + ADDR_W'((state_q == S_SHIFT_RD) ? k_dec : k_q);
	assign waddr = base + ADDR_W'((state_q == S_SHIFT_WR) ? k_q : rank_q);
	assign we    = (state_q == S_SHIFT_WR) || (state_q == S_PUT);
	assign wdata = (state_q == S_SHIFT_WR) ? rdata : v_q;

	assign addend = (fk_q == f_q) ? COL_W'(rank_q) : COL_W'(cnt_rd);

	ohe_ram #(
		.WIDTH(VALUE_WIDTH),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	ohe_unit #(
		.VW(VALUE_WIDTH),
		.SW(COL_W)
	) u_unit (
		.a  (rdata),
		.b  (v_q),
		.x  (acc_q),
		.y  (addend),
		.lt (lt),
		.eq (eq),
		.sum(sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && (operation == OP_LEARN || operation == OP_ENCODE) && !bad) begin
					state_d = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				if (k_q != n_q) begin
					state_d = S_SCAN_CMP;
				end else if (op_q == OP_LEARN) begin
					if (hit_q || 32'(n_q) >= MAX_CATEGORIES) begin
						state_d = S_IDLE;
					end else if (n_q == rank_q) begin
						state_d = S_PUT;
					end else begin
						state_d = S_SHIFT_RD;
					end
				end else if (!hit_q) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_OFFSET;
				end
			end
			S_SCAN_CMP: state_d = S_SCAN_RD;
			S_SHIFT_RD: state_d = S_SHIFT_WR;
			S_SHIFT_WR: state_d = (k_dec == rank_q) ? S_PUT : S_SHIFT_RD;
			S_PUT:      state_d = S_IDLE;
			S_OFFSET:   state_d = (fk_q == f_q) ? S_IDLE : S_OFFSET;
			default:    state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q   <= FC_W'(1);
			done_q <= 1'b0;
			for (int i = 0; i < MAX_FEATURES; i++) begin
				counts_q[i] <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				fc_q <= cfg_wr_data;
			end
			done_q <= 1'b0;
			if (accept && operation == OP_CLEAR) begin
				for (int i = 0; i < MAX_FEATURES; i++) begin
					counts_q[i] <= '0;
				end
			end
			if (state_q == S_PUT) begin
				counts_q[f_q] <= n_q + CNT_W'(1);
			end
			if (state_q == S_IDLE && accept && (operation == OP_CLEAR ||
			    operation == OP_NONE || bad)) begin
				done_q <= 1'b1;
			end
			if (state_q == S_SCAN_RD && k_q == n_q && state_d == S_IDLE) begin
				done_q <= 1'b1;
			end
			if (state_q == S_PUT || (state_q == S_OFFSET && fk_q == f_q)) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q   <= op_t'(operation);
				f_q    <= feature_index;
				v_q    <= category_value;
				n_q    <= cnt_rd;
				k_q    <= '0;
				rank_q <= '0;
				hit_q  <= 1'b0;
				fk_q   <= '0;
				acc_q  <= '0;
				status_q   <= ST_OK;
				res_rank_q <= '0;
				res_col_q  <= '0;
				res_cats_q <= '0;
				if (operation == OP_LEARN || operation == OP_ENCODE) begin
					if (bad) begin
						status_q <= ST_BAD_FEATURE;
					end
				end
			end
			S_SCAN_RD: begin
				if (k_q == n_q) begin
					k_q <= n_q;
					res_cats_q <= n_q;
					if (op_q == OP_LEARN) begin
						if (hit_q) begin
							status_q   <= ST_PRESENT;
							res_rank_q <= RANK_W'(rank_q);
						end else if (32'(n_q) >= MAX_CATEGORIES) begin
							status_q <= ST_FULL;
						end
					end else if (!hit_q) begin
						status_q <= ST_NOT_FOUND;
					end
				end
			end
			S_SCAN_CMP: begin
				k_q <= k_q + CNT_W'(1);
				if (lt) begin
					rank_q <= rank_q + CNT_W'(1);
				end
				if (eq) begin
					hit_q <= 1'b1;
				end
			end
			S_SHIFT_RD: begin
			end
			S_SHIFT_WR: begin
				k_q <= k_dec;
			end
			S_PUT: begin
				status_q   <= ST_OK;
				res_rank_q <= RANK_W'(rank_q);
				res_col_q  <= '0;
				res_cats_q <= n_q + CNT_W'(1);
			end
			S_OFFSET: begin
				acc_q <= sum;
				if (fk_q == f_q) begin
					status_q   <= ST_OK;
					res_rank_q <= RANK_W'(rank_q);
					res_col_q  <= sum;
					res_cats_q <= n_q;
				end else begin
					fk_q <= fk_q + FIDX_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign busy               = (state_q != S_IDLE);
	assign done               = done_q;
	assign status             = status_q;
	assign category_rank      = res_rank_q;
	assign onehot_column      = res_col_q;
	assign feature_categories = res_cats_q;

endmodule

/* hdl/ohe_checker.sv */
// Port-level assertions of the encoder and their binding to the top level.
module ohe_checker #(
	parameter int MAX_CATEGORIES = 16,
	parameter int RANK_W = 4,
	parameter int COL_W  = 7,
	parameter int CNT_W  = 5
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic [ohe_pkg::OP_W-1:0]     operation,
	input logic                         done,
	input logic [ohe_pkg::STATUS_W-1:0] status,
	input logic [RANK_W-1:0]            category_rank,
	input logic [COL_W-1:0]             onehot_column,
	input logic [CNT_W-1:0]             feature_categories
);

	import ohe_pkg::*;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted beat neither worked on nor answered");

	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && operation == OP_CLEAR |=> done && status == ST_OK &&
		category_rank == '0 && onehot_column == '0 && feature_categories == '0)
		else $error("clear beat gave a wrong result");

	a_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_NOT_FOUND |-> category_rank == '0 && onehot_column == '0)
		else $error("not-found result carries a rank or column");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_FULL |-> 32'(feature_categories) == MAX_CATEGORIES)
		else $error("full status with a table that is not full");

endmodule

bind one_hot_category_encoder_unit ohe_checker #(
	.MAX_CATEGORIES(MAX_CATEGORIES),
	.RANK_W(RANK_W),
	.COL_W(COL_W),
	.CNT_W(CNT_W)
) u_ohe_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.start             (start),
	.busy              (busy),
	.operation         (operation),
	.done              (done),
	.status            (status),
	.category_rank     (category_rank),
	.onehot_column     (onehot_column),
	.feature_categories(feature_categories)
);

/* tb/sv/tb_one_hot_category_encoder_unit.sv */
// Self-checking testbench of the one-hot category encoder: directed table, random phases, predictor.
module tb_one_hot_category_encoder_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import ohe_pkg::*;

	localparam int NUM_FEATURES  = 8;
	localparam int NUM_SLOTS     = 16;
	localparam int RANDOM_ITEMS  = 1300;
	localparam int SETTLE_CYCLES = 100;
	localparam int CYCLE_LIMIT   = 1000000;

	typedef struct packed {
		status_t    status;
		logic [3:0] rank;
		logic [6:0] column;
		logic [4:0] cats;
	} result_t;

	typedef struct packed {
		logic               is_cfg;
		logic [3:0]         cfg_value;
		op_t                op;
		logic [2:0]         feature;
		logic signed [15:0] value;
		logic               typed;
		result_t            want;
	} plan_row_t;

	localparam result_t ZERO_RES = '{ST_OK, 4'd0, 7'd0, 5'd0};
	localparam result_t BAD_RES  = '{ST_BAD_FEATURE, 4'd0, 7'd0, 5'd0};

	localparam plan_row_t DIRECTED_PLAN [23] = '{
		'{1'b0, 4'd0,  OP_ENCODE, 3'd0, 16'h0000, 1'b1, '{ST_NOT_FOUND, 4'd0, 7'd0, 5'd0}},
		'{1'b0, 4'd0,  OP_LEARN,  3'd1, 16'h0005, 1'b1, BAD_RES},
		'{1'b0, 4'd0,  OP_LEARN,  3'd0, 16'h8000, 1'b1, '{ST_OK, 4'd0, 7'd0, 5'd1}},
		'{1'b0, 4'd0,  OP_LEARN,  3'd0, 16'h7FFF, 1'b1, '{ST_OK, 4'd1, 7'd0, 5'd2}},
		'{1'b0, 4'd0,  OP_LEARN,  3'd0, 16'h0000, 1'b0, ZERO_RES},
		'{1'b0, 4'd0,  OP_LEARN,  3'd0, 16'h0000, 1'b1, '{ST_PRESENT, 4'd1, 7'd0, 5'd3}},
		'{1'b0, 4'd0,  OP_ENCODE, 3'd0, 16'h7FFF, 1'b1, '{ST_OK, 4'd2, 7'd2, 5'd3}},
		'{1'b0, 4'd0,  OP_NONE,   3'd7, 16'hFFFF, 1'b1, ZERO_RES},
		'{1'b1, 4'd8,  OP_CLEAR,  3'd0, 16'h0000, 1'b0, ZERO_RES},
		'{1'b0, 4'd0,  OP_LEARN,  3'd7, 16'hFFFF, 1'b0, ZERO_RES},
		'{1'b0, 4'd0,  OP_LEARN,  3'd7, 16'h5555, 1'b0, ZERO_RES},
		'{1'b0, 4'd0,  OP_LEARN,  3'd7, 16'hAAAA, 1'b0, ZERO_RES},
		'{1'b0, 4'd0,  OP_ENCODE, 3'd7, 16'h5555, 1'b0, ZERO_RES},
		'{1'b0, 4'd0,  OP_ENCODE, 3'd3, 16'h0001, 1'b1, '{ST_NOT_FOUND, 4'd0, 7'd0, 5'd0}},
		'{1'b1, 4'd15, OP_CLEAR,  3'd0, 16'h0000, 1'b0, ZERO_RES},
		'{1'b0, 4'd0,  OP_LEARN,  3'd7, 16'hFFFF, 1'b1, '{ST_PRESENT, 4'd1, 7'd0, 5'd3}},
		'{1'b0, 4'd0,  OP_ENCODE, 3'd7, 16'hAAAA, 1'b0, ZERO_RES},
		'{1'b1, 4'd0,  OP_CLEAR,  3'd0, 16'h0000, 1'b0, ZERO_RES},
		'{1'b0, 4'd0,  OP_LEARN,  3'd0, 16'h0001, 1'b1, BAD_RES},
		'{1'b0, 4'd0,  OP_ENCODE, 3'd0, 16'h0000, 1'b1, BAD_RES},
		'{1'b0, 4'd0,  OP_CLEAR,  3'd0, 16'h0000, 1'b1, ZERO_RES},
		'{1'b1, 4'd1,  OP_CLEAR,  3'd0, 16'h0000, 1'b0, ZERO_RES},
		'{1'b0, 4'd0,  OP_ENCODE, 3'd0, 16'h7FFF, 1'b1, '{ST_NOT_FOUND, 4'd0, 7'd0, 5'd0}}
	};

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [3:0]         cfg_wr_data;
	logic               start;
	logic               busy;
	logic [1:0]         operation;
	logic [2:0]         feature_index;
	logic signed [15:0] category_value;
	logic               done;
	logic [2:0]         status;
	logic [3:0]         category_rank;
	logic [6:0]         onehot_column;
	logic [4:0]         feature_categories;

	logic signed [15:0] known_values [NUM_FEATURES][NUM_SLOTS];
	int                 known_count [NUM_FEATURES];
	logic [3:0]         features_in_use;
	result_t            pending_results [$];
	int                 mismatches;
	int                 cycle_count;

	one_hot_category_encoder_unit uut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_wr_en          (cfg_wr_en),
		.cfg_wr_data        (cfg_wr_data),
		.start              (start),
		.busy               (busy),
		.operation          (operation),
		.feature_index      (feature_index),
		.category_value     (category_value),
		.done               (done),
		.status             (status),
		.category_rank      (category_rank),
		.onehot_column      (onehot_column),
		.feature_categories (feature_categories)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic result_t lookup_category(op_t op, logic [2:0] feat,
	                                            logic signed [15:0] value);
		result_t res;
		int      used;
		int      n;
		int      rank;
		int      offset;
		bit      hit;
		res = ZERO_RES;
		used = (int'(features_in_use) > NUM_FEATURES) ? NUM_FEATURES : int'(features_in_use);
		if (op == OP_CLEAR) begin
			for (int k = 0; k < NUM_FEATURES; k++) known_count[k] = 0;
			return res;
		end
		if (op == OP_NONE) return res;
		if (int'(feat) >= used) begin
			res.status = ST_BAD_FEATURE;
			return res;
		end
		n = known_count[feat];
		rank = 0;
		hit = 1'b0;
		for (int k = 0; k < n; k++) begin
			if (known_values[feat][k] < value) rank++;
			else if (known_values[feat][k] == value) hit = 1'b1;
		end
		res.cats = 5'(n);
		if (op == OP_LEARN) begin
			if (hit) begin
				res.status = ST_PRESENT;
				res.rank = 4'(rank);
			end else if (n >= NUM_SLOTS) begin
				res.status = ST_FULL;
			end else begin
				for (int k = n; k > rank; k--) known_values[feat][k] = known_values[feat][k-1];
				known_values[feat][rank] = value;
				known_count[feat] = n + 1;
				res.rank = 4'(rank);
				res.cats = 5'(n + 1);
			end
			return res;
		end
		if (!hit) begin
			res.status = ST_NOT_FOUND;
			return res;
		end
		offset = 0;
		for (int k = 0; k < int'(feat); k++) offset += known_count[k];
		res.rank = 4'(rank);
		res.column = 7'(offset + rank);
		return res;
	endfunction

	task automatic issue_command(op_t op, logic [2:0] feat, logic signed [15:0] value,
	                             int gap, bit use_typed, result_t typed_res);
		result_t predicted;
		start <= 1'b1;
		operation <= op;
		feature_index <= feat;
		category_value <= value;
		do @(posedge clk); while (busy);
		predicted = lookup_category(op, feat, value);
		pending_results.push_back(use_typed ? typed_res : predicted);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_feature_count(logic [3:0] value);
		start <= 1'b0;
		while (pending_results.size() != 0 || busy) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		features_in_use = value;
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("Result beat arrived with nothing expected.");
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, status);
					mismatches++;
				end
				if (category_rank !== want.rank) begin
					$error("category_rank: expected %0d, actual %0d", want.rank, category_rank);
					mismatches++;
				end
				if (onehot_column !== want.column) begin
					$error("onehot_column: expected %0d, actual %0d", want.column, onehot_column);
					mismatches++;
				end
				if (feature_categories !== want.cats) begin
					$error("feature_categories: expected %0d, actual %0d", want.cats,
					       feature_categories);
					mismatches++;
				end
			end
		end
	end

	initial begin
		logic signed [15:0] value_pool [40];
		int                 pool_size;
		int                 learn_pct;
		int                 phase_len;
		int                 phase;
		int                 sent;
		int                 burst_left;
		int                 gap;
		int                 pick;
		int                 used;
		bit                 quiet;
		op_t                op;
		logic [2:0]         feat;
		logic signed [15:0] value;

		mismatches = 0;
		cycle_count = 0;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= 4'd0;
		start <= 1'b0;
		operation <= OP_CLEAR;
		feature_index <= 3'd0;
		category_value <= 16'sd0;
		for (int k = 0; k < NUM_FEATURES; k++) known_count[k] = 0;
		features_in_use = 4'd1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_PLAN[i]) begin
			if (DIRECTED_PLAN[i].is_cfg)
				write_feature_count(DIRECTED_PLAN[i].cfg_value);
			else
				issue_command(DIRECTED_PLAN[i].op, DIRECTED_PLAN[i].feature,
				              DIRECTED_PLAN[i].value, $urandom_range(2), DIRECTED_PLAN[i].typed,
				              DIRECTED_PLAN[i].want);
		end

		sent = 0;
		phase = 0;
		burst_left = 0;
		while (sent < RANDOM_ITEMS) begin
			if (phase == 0) begin
				write_feature_count(4'd8);
				learn_pct = 85;
				pool_size = 32;
				phase_len = 300;
			end else begin
				pick = $urandom_range(9);
				if (pick == 0) write_feature_count(4'd0);
				else if (pick == 1) write_feature_count(4'($urandom_range(15, 9)));
				else write_feature_count(4'($urandom_range(8, 1)));
				learn_pct = $urandom_range(70, 20);
				pool_size = $urandom_range(40, 4);
				phase_len = $urandom_range(160, 60);
			end
			quiet = ($urandom_range(3) == 0);
			for (int k = 0; k < pool_size; k++) value_pool[k] = 16'($urandom);
			value_pool[0] = 16'h8000;
			value_pool[1] = 16'h7FFF;
			used = (int'(features_in_use) > NUM_FEATURES) ? NUM_FEATURES : int'(features_in_use);
			if (phase > 0 && $urandom_range(2) == 0) begin
				issue_command(OP_CLEAR, 3'd0, 16'sd0, 0, 1'b0, ZERO_RES);
				sent++;
			end
			for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
				pick = $urandom_range(99);
				if (pick < 1) op = OP_CLEAR;
				else if (pick < 3) op = OP_NONE;
				else if (pick < 3 + learn_pct) op = OP_LEARN;
				else op = OP_ENCODE;
				if (used == 0 || $urandom_range(99) < 12) feat = 3'($urandom_range(7));
				else feat = 3'($urandom_range(used - 1));
				if ($urandom_range(99) < 80) value = value_pool[$urandom_range(pool_size - 1)];
				else value = 16'($urandom);
				if (burst_left == 0) burst_left = $urandom_range(24, 1);
				burst_left--;
				gap = (burst_left == 0 && !quiet) ? $urandom_range(8, 1) : 0;
				issue_command(op, feat, value, gap, 1'b0, ZERO_RES);
				sent++;
			end
			phase++;
		end

		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
